// ===== hdl/sec_pkg.sv =====
package sec_pkg;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_SPHERE = 2'd1;
  localparam logic [1:0] STATUS_FAIL   = 2'd2;

  localparam logic [6:0] WORD_STEPS = 7'd64;
  localparam logic [6:0] ROOT_STEPS = 7'd32;

endpackage

// ===== hdl/sec_arith.sv =====
// shared bit-serial unit: shift-add multiply, restoring divide, digit-by-digit root
module sec_arith (
  input  logic                clk,
  input  logic                rst_n,
  input  sec_pkg::arith_req_t req,
  input  logic [63:0]         opa,
  input  logic [63:0]         opb,
  output logic                done,
  output logic [63:0]         res_hi,
  output logic [63:0]         res_lo,
  output logic [31:0]         res_root
);

  logic [127:0]       acc_r;
  logic [63:0]        arg_r;
  logic [31:0]        root_r;
  logic [6:0]         cnt_r;
  logic               busy_r;
  logic               done_r;
  sec_pkg::arith_op_t op_r;

  logic [64:0] mul_sum;
  logic [64:0] div_trial;
  logic [35:0] sq_rem;
  logic [36:0] sq_trial;

  always_comb begin
    mul_sum   = {1'b0, acc_r[127:64]} + (acc_r[0] ? {1'b0, arg_r} : 65'd0);
    div_trial = {acc_r[127:64], acc_r[63]} - {1'b0, arg_r};
    sq_rem    = {acc_r[97:64], acc_r[63:62]};
    sq_trial  = {1'b0, sq_rem} - {3'b000, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          op_r   <= req.op;
          root_r <= 32'd0;
          unique case (req.op)
            sec_pkg::OP_MUL: begin
              acc_r <= {64'd0, opb};
              arg_r <= opa;
              cnt_r <= sec_pkg::WORD_STEPS;
            end
            sec_pkg::OP_DIV: begin
              acc_r <= {64'd0, opa};
              arg_r <= opb;
              cnt_r <= sec_pkg::WORD_STEPS;
            end
            sec_pkg::OP_SQRT: begin
              acc_r <= {64'd0, opa};
              arg_r <= opb;
              cnt_r <= sec_pkg::ROOT_STEPS;
            end
            default: busy_r <= 1'b0;
          endcase
        end
      end else begin
        unique case (op_r)
          sec_pkg::OP_MUL: acc_r <= {mul_sum, acc_r[63:1]};
          sec_pkg::OP_DIV: begin
            if (!div_trial[64]) begin
              acc_r <= {div_trial[63:0], acc_r[62:0], 1'b1};
            end else begin
              acc_r <= {acc_r[126:0], 1'b0};
            end
          end
          sec_pkg::OP_SQRT: begin
            if (!sq_trial[36]) begin
              acc_r[127:64] <= 64'(sq_trial[35:0]);
              root_r        <= {root_r[30:0], 1'b1};
            end else begin
              acc_r[127:64] <= 64'(sq_rem);
              root_r        <= {root_r[30:0], 1'b0};
            end
            acc_r[63:0] <= {acc_r[61:0], 2'b00};
          end
          default: acc_r <= acc_r;
        endcase
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign res_hi   = acc_r[127:64];
  assign res_lo   = acc_r[63:0];
  assign res_root = root_r;

endmodule

// ===== hdl/segment_ellipsoid_cholesky_unit.sv =====
// Segment ellipsoid unit. Each accepted waypoint word (signed fixed point) is compared with the
// previous waypoint of the path; a word flagged path_start, or the first after reset, is only
// stored. Every later word yields one result word: the segment midpoint (rounded toward minus
// infinity) and the lower-triangular Cholesky factor of
// mu*mu^T*(d^2/4) + (I - mu*mu^T)*epsilon^2, with status 0. Coincident waypoints give the
// epsilon sphere with status 1; epsilon of zero or a non-positive pivot give the epsilon sphere
// with status 2. All arithmetic runs through one bit-serial unit that retires one bit per cycle
// (one root bit per cycle for square roots): a normal segment takes 23 multiplies, 6 divides and
// 4 square roots, plus the normalization shifts. Stored-only words leave the block idle, and
// sphere results go straight to the output stage without using the arithmetic unit.
// One item is worked at a time; the input is taken again as soon as a result is parked in the
// output register, even while that word still waits for out_ready. The epsilon register resets
// to 0.5 (32768) and is written through the cfg channel, which is always ready.
module segment_ellipsoid_cholesky_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [30:0]            cfg_epsilon,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] in_pos_x,
  input  logic [COORD_WIDTH-1:0] in_pos_y,
  input  logic [COORD_WIDTH-1:0] in_pos_z,
  input  logic                   in_path_start,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] out_center_x,
  output logic [COORD_WIDTH-1:0] out_center_y,
  output logic [COORD_WIDTH-1:0] out_center_z,
  output logic [30:0]            out_l11,
  output logic [31:0]            out_l21,
  output logic [30:0]            out_l22,
  output logic [31:0]            out_l31,
  output logic [31:0]            out_l32,
  output logic [30:0]            out_l33,
  output logic [1:0]             out_status
);

  localparam int CW = COORD_WIDTH;
  // normalized direction needs at least 31 bits of headroom
  localparam int UW = (CW + 1 > 31) ? CW + 1 : 31;
  localparam logic [30:0] EpsReset = 31'd32768;
  localparam logic [30:0] LSat     = 31'h7FFF_FFFF;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_EPS, S_NORM, S_USQ, S_RSQ, S_MU, S_MMA, S_MMB,
    S_C1, S_C2, S_C3, S_C4M, S_C4S, S_C5M, S_C5D, S_C6M, S_C6N, S_C6S, S_OUT
  } state_t;

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [30:0] clamp31(input logic [63:0] q);
    return (q > 64'(LSat)) ? LSat : q[30:0];
  endfunction

  state_t state_r;
  logic   issued_r;
  logic   have_prev_r;
  logic   out_valid_r;
  logic [30:0] eps_r;

  // waypoint history and per-segment working set
  logic [CW-1:0]        prev_r   [3];
  logic [CW-1:0]        center_r [3];
  logic [CW:0]          mag_r    [3];
  logic                 neg_r    [3];
  logic [UW-1:0]        u_r      [3];
  logic [30:0]          mu_r     [3];
  logic signed [63:0]   m_r      [6];
  logic [30:0]          om_r     [3];  // |l21|, |l31|, |l32| after clamping
  logic                 on_r     [3];
  logic [1:0]  k_r;
  logic [2:0]  pair_r;
  logic [63:0] s_r;
  logic [61:0] b_r;
  logic [61:0] usum_r;
  logic [30:0] r_r;
  logic        dneg_r;
  logic [61:0] dmag_r;
  logic [60:0] pm_r;
  logic [65:0] p_r;
  logic [31:0] l11_r, l22_r, l33_r;
  logic [1:0]  status_r;

  logic [CW-1:0]       out_center_r [3];
  logic [30:0]         out_l11_r, out_l22_r, out_l33_r;
  logic [31:0]         out_l21_r, out_l31_r, out_l32_r;
  logic [1:0]          out_status_r;

  // arithmetic unit hookup
  sec_pkg::arith_req_t ar_req;
  sec_pkg::arith_op_t  op_kind;
  logic [63:0] opa, opb;
  logic        op_start, op_state, check_fail;
  logic        ar_done;
  logic [63:0] ar_hi, ar_lo;
  logic [31:0] ar_root;

  sec_arith u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (ar_req),
    .opa      (opa),
    .opb      (opb),
    .done     (ar_done),
    .res_hi   (ar_hi),
    .res_lo   (ar_lo),
    .res_root (ar_root)
  );

  // incoming waypoint against the stored one
  logic [CW-1:0] pin     [3];
  logic [CW:0]   diff_in [3];
  logic [CW:0]   csum_in [3];
  logic [CW:0]   dmag_in [3];
  logic          dneg_in [3];
  logic          mag_zero;

  assign pin[0] = in_pos_x;
  assign pin[1] = in_pos_y;
  assign pin[2] = in_pos_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_in[k] = {pin[k][CW-1], pin[k]} - {prev_r[k][CW-1], prev_r[k]};
      csum_in[k] = {pin[k][CW-1], pin[k]} + {prev_r[k][CW-1], prev_r[k]};
      dneg_in[k] = diff_in[k][CW];
      dmag_in[k] = dneg_in[k] ? (~diff_in[k] + 1'b1) : diff_in[k];
    end
    mag_zero = (dmag_in[0] == '0) && (dmag_in[1] == '0) && (dmag_in[2] == '0);
  end

  // squared-length accumulation with saturation
  logic [63:0] mag_ext;
  logic [63:0] sq_val;
  logic [64:0] s_add;
  always_comb begin
    mag_ext = 64'(mag_r[k_r]);
    sq_val  = (|mag_ext[63:32]) ? '1 : ar_lo;
    s_add   = {1'b0, s_r} + {1'b0, sq_val};
  end

  // normalization tests
  logic u_hi, u_lo;
  always_comb begin
    u_hi = (|u_r[0][UW-1:30]) | (|u_r[1][UW-1:30]) | (|u_r[2][UW-1:30]);
    u_lo = ~((|u_r[0][UW-1:29]) | (|u_r[1][UW-1:29]) | (|u_r[2][UW-1:29]));
  end

  // a = d^2/4 against b = epsilon^2
  logic [61:0] a_val;
  always_comb begin
    a_val = s_r[63:2];
  end

  // matrix element pair decode: 00, 10, 11, 20, 21, 22
  logic [30:0] mu_i, mu_j;
  logic        neg_i, neg_j, pdiag;
  always_comb begin
    unique case (pair_r)
      3'd1: begin mu_i = mu_r[1]; mu_j = mu_r[0]; neg_i = neg_r[1]; neg_j = neg_r[0]; pdiag = 1'b0; end
      3'd2: begin mu_i = mu_r[1]; mu_j = mu_r[1]; neg_i = neg_r[1]; neg_j = neg_r[1]; pdiag = 1'b1; end
      3'd3: begin mu_i = mu_r[2]; mu_j = mu_r[0]; neg_i = neg_r[2]; neg_j = neg_r[0]; pdiag = 1'b0; end
      3'd4: begin mu_i = mu_r[2]; mu_j = mu_r[1]; neg_i = neg_r[2]; neg_j = neg_r[1]; pdiag = 1'b0; end
      3'd5: begin mu_i = mu_r[2]; mu_j = mu_r[2]; neg_i = neg_r[2]; neg_j = neg_r[2]; pdiag = 1'b1; end
      default: begin
        mu_i = mu_r[0]; mu_j = mu_r[0]; neg_i = neg_r[0]; neg_j = neg_r[0]; pdiag = 1'b1;
      end
    endcase
  end

  // scaled term floor(|a-b| * mu_i*mu_j / 2^60) with its sign, plus b on the diagonal
  logic [63:0] t_val;
  logic [64:0] tv;
  always_comb begin
    t_val = {ar_hi[59:0], ar_lo[63:60]};
    tv    = (dneg_r ^ neg_i ^ neg_j) ? (~{1'b0, t_val} + 65'd1) : {1'b0, t_val};
    if (pdiag) begin
      tv = tv + 65'(b_r);
    end
  end

  logic [65:0] prod66;
  logic [65:0] p_abs;
  always_comb begin
    prod66 = {2'b00, ar_lo};
    p_abs  = p_r[65] ? (~p_r + 66'd1) : p_r;
  end

  // operand selection and pivot checks
  always_comb begin
    op_kind    = sec_pkg::OP_MUL;
    opa        = 64'd0;
    opb        = 64'd0;
    op_state   = 1'b1;
    check_fail = 1'b0;
    unique case (state_r)
      S_SQ:  begin opa = mag_ext; opb = mag_ext; end
      S_EPS: begin opa = 64'(eps_r); opb = 64'(eps_r); end
      S_USQ: begin opa = 64'(u_r[k_r]); opb = 64'(u_r[k_r]); end
      S_RSQ: begin op_kind = sec_pkg::OP_SQRT; opa = 64'(usum_r); end
      S_MU: begin
        op_kind = sec_pkg::OP_DIV;
        opa     = {4'd0, u_r[k_r][29:0], 30'd0};
        opb     = 64'(r_r);
      end
      S_MMA: begin opa = 64'(mu_i); opb = 64'(mu_j); end
      S_MMB: begin opa = 64'(dmag_r); opb = 64'(pm_r); end
      S_C1: begin
        op_kind    = sec_pkg::OP_SQRT;
        opa        = m_r[0];
        check_fail = m_r[0][63] || (m_r[0] == 64'sd0);
      end
      S_C2: begin op_kind = sec_pkg::OP_DIV; opa = abs64(m_r[1]); opb = 64'(l11_r); end
      S_C3: begin op_kind = sec_pkg::OP_DIV; opa = abs64(m_r[3]); opb = 64'(l11_r); end
      S_C4M: begin opa = 64'(om_r[0]); opb = 64'(om_r[0]); end
      S_C4S, S_C6S: begin
        op_kind    = sec_pkg::OP_SQRT;
        opa        = p_r[63:0];
        check_fail = p_r[65] || (p_r == 66'd0);
      end
      S_C5M: begin opa = 64'(om_r[1]); opb = 64'(om_r[0]); end
      S_C5D: begin op_kind = sec_pkg::OP_DIV; opa = p_abs[63:0]; opb = 64'(l22_r); end
      S_C6M: begin opa = 64'(om_r[1]); opb = 64'(om_r[1]); end
      S_C6N: begin opa = 64'(om_r[2]); opb = 64'(om_r[2]); end
      default: op_state = 1'b0;
    endcase
    op_start = op_state && !issued_r && !check_fail;
  end

  assign ar_req.start = op_start;
  assign ar_req.op    = op_kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
      eps_r       <= EpsReset;
    end else begin
      if (cfg_valid) begin
        eps_r <= cfg_epsilon;
      end
      // a word parked in the same cycle keeps the output valid
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      if (op_start) begin
        issued_r <= 1'b1;
      end
      if (ar_done) begin
        issued_r <= 1'b0;
      end
      if (op_state && !issued_r && check_fail) begin
        status_r <= sec_pkg::STATUS_FAIL;
        state_r  <= S_OUT;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            for (int k = 0; k < 3; k++) begin
              prev_r[k]   <= pin[k];
              center_r[k] <= csum_in[k][CW:1];
              mag_r[k]    <= dmag_in[k];
              neg_r[k]    <= dneg_in[k];
            end
            have_prev_r <= 1'b1;
            if (!in_path_start && have_prev_r) begin
              if (mag_zero) begin
                status_r <= sec_pkg::STATUS_SPHERE;
                state_r  <= S_OUT;
              end else if (eps_r == 31'd0) begin
                status_r <= sec_pkg::STATUS_FAIL;
                state_r  <= S_OUT;
              end else begin
                k_r     <= 2'd0;
                s_r     <= 64'd0;
                state_r <= S_SQ;
              end
            end
          end
        end
        S_SQ: begin
          if (ar_done) begin
            s_r <= s_add[64] ? '1 : s_add[63:0];
            if (k_r == 2'd2) begin
              state_r <= S_EPS;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        S_EPS: begin
          if (ar_done) begin
            b_r <= ar_lo[61:0];
            for (int k = 0; k < 3; k++) begin
              u_r[k] <= UW'(mag_r[k]);
            end
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // bring the largest component into [2^29, 2^30)
          if (u_hi) begin
            for (int k = 0; k < 3; k++) begin
              u_r[k] <= u_r[k] >> 1;
            end
          end else if (u_lo) begin
            for (int k = 0; k < 3; k++) begin
              u_r[k] <= u_r[k] << 1;
            end
          end else begin
            k_r     <= 2'd0;
            usum_r  <= 62'd0;
            state_r <= S_USQ;
          end
        end
        S_USQ: begin
          if (ar_done) begin
            usum_r <= usum_r + ar_lo[61:0];
            if (k_r == 2'd2) begin
              state_r <= S_RSQ;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        S_RSQ: begin
          if (ar_done) begin
            r_r     <= ar_root[30:0];
            k_r     <= 2'd0;
            state_r <= S_MU;
          end
        end
        S_MU: begin
          if (ar_done) begin
            mu_r[k_r] <= ar_lo[30:0];
            if (k_r == 2'd2) begin
              dneg_r  <= a_val < b_r;
              dmag_r  <= (a_val < b_r) ? (b_r - a_val) : (a_val - b_r);
              pair_r  <= 3'd0;
              state_r <= S_MMA;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        S_MMA: begin
          if (ar_done) begin
            pm_r    <= ar_lo[60:0];
            state_r <= S_MMB;
          end
        end
        S_MMB: begin
          if (ar_done) begin
            m_r[pair_r] <= tv[63:0];
            if (pair_r == 3'd5) begin
              state_r <= S_C1;
            end else begin
              pair_r  <= pair_r + 3'd1;
              state_r <= S_MMA;
            end
          end
        end
        S_C1: begin
          if (ar_done) begin
            l11_r   <= ar_root;
            state_r <= S_C2;
          end
        end
        S_C2: begin
          if (ar_done) begin
            om_r[0] <= clamp31(ar_lo);
            on_r[0] <= m_r[1][63];
            state_r <= S_C3;
          end
        end
        S_C3: begin
          if (ar_done) begin
            om_r[1] <= clamp31(ar_lo);
            on_r[1] <= m_r[3][63];
            state_r <= S_C4M;
          end
        end
        S_C4M: begin
          if (ar_done) begin
            p_r     <= 66'(m_r[2]) - prod66;
            state_r <= S_C4S;
          end
        end
        S_C4S: begin
          if (ar_done) begin
            l22_r   <= ar_root;
            state_r <= S_C5M;
          end
        end
        S_C5M: begin
          if (ar_done) begin
            // M21 - l31*l21
            p_r     <= (on_r[0] ^ on_r[1]) ? (66'(m_r[4]) + prod66) : (66'(m_r[4]) - prod66);
            state_r <= S_C5D;
          end
        end
        S_C5D: begin
          if (ar_done) begin
            om_r[2] <= clamp31(ar_lo);
            on_r[2] <= p_r[65];
            state_r <= S_C6M;
          end
        end
        S_C6M: begin
          if (ar_done) begin
            p_r     <= 66'(m_r[5]) - prod66;
            state_r <= S_C6N;
          end
        end
        S_C6N: begin
          if (ar_done) begin
            p_r     <= p_r - prod66;
            state_r <= S_C6S;
          end
        end
        S_C6S: begin
          if (ar_done) begin
            l33_r    <= ar_root;
            status_r <= sec_pkg::STATUS_OK;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          // park the result once the output register is free
          if (!out_valid_r || out_ready) begin
            for (int k = 0; k < 3; k++) begin
              out_center_r[k] <= center_r[k];
            end
            out_status_r <= status_r;
            if (status_r != sec_pkg::STATUS_OK) begin
              out_l11_r <= eps_r;
              out_l22_r <= eps_r;
              out_l33_r <= eps_r;
              out_l21_r <= 32'd0;
              out_l31_r <= 32'd0;
              out_l32_r <= 32'd0;
            end else begin
              out_l11_r <= l11_r[30:0];
              out_l22_r <= l22_r[30:0];
              out_l33_r <= l33_r[30:0];
              out_l21_r <= on_r[0] ? (~{1'b0, om_r[0]} + 32'd1) : {1'b0, om_r[0]};
              out_l31_r <= on_r[1] ? (~{1'b0, om_r[1]} + 32'd1) : {1'b0, om_r[1]};
              out_l32_r <= on_r[2] ? (~{1'b0, om_r[2]} + 32'd1) : {1'b0, om_r[2]};
            end
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready    = 1'b1;
  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_center_x = out_center_r[0];
  assign out_center_y = out_center_r[1];
  assign out_center_z = out_center_r[2];
  assign out_l11      = out_l11_r;
  assign out_l21      = out_l21_r;
  assign out_l22      = out_l22_r;
  assign out_l31      = out_l31_r;
  assign out_l32      = out_l32_r;
  assign out_l33      = out_l33_r;
  assign out_status   = out_status_r;

endmodule

// ===== hdl/sec_checker.sv =====
module sec_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] out_l11,
  input logic [31:0] out_l21,
  input logic [30:0] out_l22,
  input logic [31:0] out_l31,
  input logic [31:0] out_l32,
  input logic [30:0] out_l33,
  input logic [1:0]  out_status
);

  // only the three defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == sec_pkg::STATUS_OK || out_status == sec_pkg::STATUS_SPHERE ||
                   out_status == sec_pkg::STATUS_FAIL))
    else $error("undefined status code");

  // fallback results are the epsilon sphere
  a_sphere: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != sec_pkg::STATUS_OK) |->
      (out_l21 == 32'd0 && out_l31 == 32'd0 && out_l32 == 32'd0 &&
       out_l11 == out_l22 && out_l22 == out_l33))
    else $error("fallback result is not a sphere");

  // a new result only appears after the input side was closed
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_l11) && $stable(out_status)))
    else $error("stalled result word changed");

endmodule

bind segment_ellipsoid_cholesky_unit sec_checker u_sec_checker (.*);

// ===== tb/segment_ellipsoid_cholesky_unit_tb.sv =====
`timescale 1ns / 1ps

module segment_ellipsoid_cholesky_unit_tb;

  // run limit: ample margin over the work of all full segments
  localparam int unsigned CYCLE_LIMIT = 12000000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS = 200;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        start;
  } waypoint_t;

  typedef struct {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [30:0] l11;
    logic [31:0] l21;
    logic [30:0] l22;
    logic [31:0] l31;
    logic [31:0] l32;
    logic [30:0] l33;
    logic [1:0]  status;
  } ellipsoid_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [30:0] cfg_epsilon = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_pos_x = '0;
  logic [31:0] in_pos_y = '0;
  logic [31:0] in_pos_z = '0;
  logic in_path_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_center_x, out_center_y, out_center_z;
  logic [30:0] out_l11, out_l22, out_l33;
  logic [31:0] out_l21, out_l31, out_l32;
  logic [1:0] out_status;

  segment_ellipsoid_cholesky_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_epsilon(cfg_epsilon),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_path_start(in_path_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_center_x(out_center_x), .out_center_y(out_center_y),
    .out_center_z(out_center_z),
    .out_l11(out_l11), .out_l21(out_l21), .out_l22(out_l22),
    .out_l31(out_l31), .out_l32(out_l32), .out_l33(out_l33),
    .out_status(out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // predictor state, mirrors the block's registers
  logic [30:0] eps_shadow = 31'd32768;
  longint      last_x = 0, last_y = 0, last_z = 0;
  logic        has_last = 1'b0;

  waypoint_t  pending_words[$];
  ellipsoid_t expected_shapes[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r, bw;
    r = '0;
    bw = 64'h4000_0000_0000_0000;
    while (bw > v) bw = bw >> 2;
    while (bw != 0) begin
      if (v >= r + bw) begin
        v = v - (r + bw);
        r = (r >> 1) + bw;
      end else begin
        r = r >> 1;
      end
      bw = bw >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp_off(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483647) return -64'sd2147483647;
    return v;
  endfunction

  // cholesky of the segment matrix; returns 0 on a non-positive pivot
  function automatic bit cholesky(input logic [63:0] mag[3], input bit neg[3],
                                  output longint lf[6]);
    logic [63:0] s, sq, a, b, umax, r, dmag, t;
    logic [63:0] u[3], mu[3];
    logic [64:0] acc;
    logic [127:0] prod;
    longint mm[3][3];
    longint p2, p3, tv;
    bit dneg, sg;
    s = '0;
    umax = '0;
    for (int i = 0; i < 3; i++) begin
      sq = (mag[i] >= 64'h1_0000_0000) ? '1 : mag[i] * mag[i];
      acc = {1'b0, s} + {1'b0, sq};
      s = acc[64] ? '1 : acc[63:0];
      u[i] = mag[i];
      if (mag[i] > umax) umax = mag[i];
    end
    a = s >> 2;
    if (a > 64'h3FFF_FFFF_FFFF_FFFF) a = 64'h3FFF_FFFF_FFFF_FFFF;
    b = {33'd0, eps_shadow} * {33'd0, eps_shadow};
    // normalize direction so the largest magnitude sits in [2^29, 2^30)
    while (umax >= 64'h4000_0000) begin
      umax = umax >> 1;
      for (int i = 0; i < 3; i++) u[i] = u[i] >> 1;
    end
    while (umax < 64'h2000_0000) begin
      umax = umax << 1;
      for (int i = 0; i < 3; i++) u[i] = u[i] << 1;
    end
    r = isqrt64(u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
    for (int i = 0; i < 3; i++) mu[i] = (u[i] << 30) / r;
    dneg = a < b;
    dmag = dneg ? b - a : a - b;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j <= i; j++) begin
        prod = {64'd0, dmag} * {64'd0, mu[i] * mu[j]};
        t = prod[123:60];
        sg = dneg ^ neg[i] ^ neg[j];
        tv = sg ? -longint'(t) : longint'(t);
        if (i == j) tv = tv + longint'(b);
        mm[i][j] = tv;
      end
    for (int k = 0; k < 6; k++) lf[k] = 0;
    if (mm[0][0] <= 0) return 1'b0;
    lf[0] = longint'(isqrt64(mm[0][0]));
    lf[1] = clamp_off(mm[1][0] / lf[0]);
    lf[3] = clamp_off(mm[2][0] / lf[0]);
    p2 = mm[1][1] - lf[1] * lf[1];
    if (p2 <= 0) return 1'b0;
    lf[2] = longint'(isqrt64(p2));
    lf[4] = clamp_off((mm[2][1] - lf[3] * lf[1]) / lf[2]);
    p3 = mm[2][2] - lf[3] * lf[3];
    p3 = p3 - lf[4] * lf[4];
    if (p3 <= 0) return 1'b0;
    lf[5] = longint'(isqrt64(p3));
    return 1'b1;
  endfunction

  // expected ellipsoid for the segment from the stored waypoint to w
  function automatic ellipsoid_t segment_shape(input waypoint_t w);
    ellipsoid_t e;
    longint p[3], q[3], d, mid;
    logic [63:0] mag[3];
    bit neg[3];
    longint lf[6];
    p[0] = longint'(signed'(w.x));
    p[1] = longint'(signed'(w.y));
    p[2] = longint'(signed'(w.z));
    q[0] = last_x;
    q[1] = last_y;
    q[2] = last_z;
    for (int i = 0; i < 3; i++) begin
      d = p[i] - q[i];
      neg[i] = d < 0;
      mag[i] = neg[i] ? -d : d;
      mid = (p[i] + q[i]) >>> 1;
      if (i == 0) e.cx = mid[31:0];
      else if (i == 1) e.cy = mid[31:0];
      else e.cz = mid[31:0];
    end
    if ((mag[0] | mag[1] | mag[2]) == 0) e.status = sec_pkg::STATUS_SPHERE;
    else if (eps_shadow == 0) e.status = sec_pkg::STATUS_FAIL;
    else e.status = cholesky(mag, neg, lf) ? sec_pkg::STATUS_OK : sec_pkg::STATUS_FAIL;
    if (e.status != sec_pkg::STATUS_OK) begin
      lf[0] = eps_shadow;
      lf[2] = eps_shadow;
      lf[5] = eps_shadow;
      lf[1] = 0;
      lf[3] = 0;
      lf[4] = 0;
    end
    e.l11 = lf[0][30:0];
    e.l21 = lf[1][31:0];
    e.l22 = lf[2][30:0];
    e.l31 = lf[3][31:0];
    e.l32 = lf[4][31:0];
    e.l33 = lf[5][30:0];
    return e;
  endfunction

  // driver: take the accepted word into the predictor, then offer the next
  always @(posedge clk) begin
    waypoint_t w;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        w.x = in_pos_x;
        w.y = in_pos_y;
        w.z = in_pos_z;
        w.start = in_path_start;
        if (has_last && !w.start) begin
          expected_shapes.insert(expected_shapes.size(), segment_shape(w));
        end
        last_x = longint'(signed'(w.x));
        last_y = longint'(signed'(w.y));
        last_z = longint'(signed'(w.z));
        has_last = 1'b1;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          in_pos_x <= w.x;
          in_pos_y <= w.y;
          in_pos_z <= w.z;
          in_path_start <= w.start;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // monitor: compare each result word against the oldest expectation
  always @(posedge clk) begin
    ellipsoid_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_shapes.size() == 0) begin
          error_count++;
          $display("%0t unexpected result word: expected none actual status %h",
                   $time, out_status);
        end else begin
          e = expected_shapes.pop_front();
          check_field("center_x", e.cx, out_center_x);
          check_field("center_y", e.cy, out_center_y);
          check_field("center_z", e.cz, out_center_z);
          check_field("l11", {1'b0, e.l11}, {1'b0, out_l11});
          check_field("l21", e.l21, out_l21);
          check_field("l22", {1'b0, e.l22}, {1'b0, out_l22});
          check_field("l31", e.l31, out_l31);
          check_field("l32", e.l32, out_l32);
          check_field("l33", {1'b0, e.l33}, {1'b0, out_l33});
          check_field("status", {30'd0, e.status}, {30'd0, out_status});
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[segment_ellipsoid_cholesky_unit] ERROR");
      $finish;
    end
  end

  task automatic write_epsilon(input logic [30:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_epsilon <= v;
    do @(posedge clk); while (!cfg_ready);
    eps_shadow = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_word(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic start);
    waypoint_t w;
    w.x = x;
    w.y = y;
    w.z = z;
    w.start = start;
    pending_words.insert(pending_words.size(), w);
  endtask

  // wait until the block has drained everything handed to it
  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_shapes.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed paths with random steps of mixed size
  task automatic queue_random_path_words(input int unsigned n);
    logic [31:0] x, y, z, dx;
    int unsigned kind;
    x = $urandom;
    y = $urandom;
    z = $urandom;
    queue_word(x, y, z, 1'b1);
    for (int unsigned k = 1; k < n; k++) begin
      kind = $urandom_range(99);
      if (kind < 6) begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
        queue_word(x, y, z, 1'b1);
      end else if (kind < 11) begin
        queue_word(x, y, z, 1'b0);
      end else if (kind < 40) begin
        x = x + $urandom_range(512) - 256;
        y = y + $urandom_range(512) - 256;
        z = z + $urandom_range(512) - 256;
        queue_word(x, y, z, 1'b0);
      end else if (kind < 70) begin
        x = x + ($urandom >>> 10) - 32'h0020_0000;
        y = y + ($urandom >>> 10) - 32'h0020_0000;
        z = z + ($urandom >>> 10) - 32'h0020_0000;
        queue_word(x, y, z, 1'b0);
      end else if (kind < 85) begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
        queue_word(x, y, z, 1'b0);
      end else begin
        // step along a single axis
        dx = $urandom >> $urandom_range(31);
        case ($urandom_range(2))
          0: x = x + dx;
          1: y = y - dx;
          default: z = z + dx;
        endcase
        queue_word(x, y, z, 1'b0);
      end
    end
  endtask

  initial begin
    logic [30:0] eps_list[6];
    int unsigned idle_modes[4][2];
    eps_list = '{31'd65536, 31'd0, 31'h7FFF_FFFF, 31'd1, 31'd32768, 31'd1000};
    idle_modes = '{'{0, 0}, '{87, 0}, '{0, 87}, '{7, 7}};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset epsilon, first word without path_start is only stored
    queue_word(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
    queue_word(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);  // coincident
    queue_word(32'h0005_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);  // +x axis
    queue_word(32'h0005_0000, 32'hFFFE_0000, 32'h0003_0000, 1'b0);  // -y axis
    queue_word(32'h0005_0000, 32'hFFFE_0000, 32'h0013_0000, 1'b0);  // +z axis
    queue_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);  // general direction
    queue_word(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b0);  // tiny, pivot fails
    queue_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);  // new path at max
    queue_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);  // longest step
    queue_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    queue_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    queue_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);  // coincident at min
    queue_word(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b1);
    queue_word(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);  // odd midpoint
    queue_word(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b0);
    queue_word(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b1);  // restart, no result
    queue_word(32'h1235_5678, 32'h9ABB_DEF0, 32'h0F10_0F0F, 1'b0);
    wait_idle();

    // epsilon extremes, including zero for the singular case
    write_epsilon(31'd0);
    queue_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    queue_word(32'h0003_0000, 32'h0004_0000, 32'h0000_0000, 1'b0);
    queue_word(32'h0003_0000, 32'h0004_0000, 32'h0000_0000, 1'b0);
    wait_idle();
    write_epsilon(31'h7FFF_FFFF);
    queue_word(32'h0003_0000, 32'h0004_0000, 32'h0000_0000, 1'b0);
    queue_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
    wait_idle();

    // random phases, each with its own epsilon and idling pattern
    for (int ph = 0; ph < 6; ph++) begin
      write_epsilon(ph == 4 ? 31'($urandom) : eps_list[ph]);
      send_idle_pct = idle_modes[ph % 4][0];
      recv_stall_pct = idle_modes[ph % 4][1];
      queue_random_path_words(PHASE_ITEMS);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("[segment_ellipsoid_cholesky_unit] OK");
    end else begin
      $display("[segment_ellipsoid_cholesky_unit] ERROR");
    end
    $finish;
  end

endmodule
